// File: design/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants of the burner frame receiver
// Holds the payload structs, the result kind codes and the frame phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bfr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h5A;
  localparam logic [7:0] CHK_XOR   = 8'hFF;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd32;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_OK      = 3'd1,
    KIND_SYNC    = 3'd2,
    KIND_LEN     = 3'd3,
    KIND_CHK     = 3'd4,
    KIND_TIMEOUT = 3'd5
  } kind_e;

  // One-hot frame phase
  typedef enum logic [5:0] {
    PH_SYNC1   = 6'b000001,
    PH_SYNC2   = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CHECK   = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic       last;
  } out_t;

  typedef struct packed {
    phase_e     phase;
    logic       sync_good;
    logic [7:0] frame_len;
    logic [7:0] byte_count;
    logic [7:0] sum_acc;
  } state_t;

endpackage

`default_nettype wire

// File: design/burner_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// burner_frame_receiver_core: serial frame receiver for a burner controller
// Parses sync, length, obfuscated payload and checksum from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): one received byte per
//     transfer, or an abort flag that stands for a read timeout.
//   out channel (out_valid_o/out_ready_i/out_data_o): de-obfuscated payload
//     bytes and one status result per frame (ok, bad sync, length error,
//     bad checksum, timeout), the status result flagged with last.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes max_payload,
//     always ready; write it only while the block is idle.
// Timing: a result shows on the out channel in the cycle after the transfer
//   of the byte that causes it. Throughput: one byte per cycle unless a
//   stalled result holds in_ready_o low; the whole parser update is a single
//   pass through bfr_step into the state and result registers.
// Reset: the parser hunts for the first sync byte, max_payload is 32 and
//   the result register is empty.
// Stall: while a result waits and out_ready_i is low, in_ready_o is low;
//   the result register frees and refills in the same cycle otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module burner_frame_receiver_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfr_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfr_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i
);
  import bfr_pkg::*;

  state_t     state_q, state_d;
  logic [7:0] max_payload_q;
  logic       out_valid_q;
  out_t       out_data_q;
  logic       res_valid;
  out_t       res;
  logic       in_xfer;

  // Accept while the result register is empty or being drained this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bfr_step u_step (
    .cur_i         (state_q),
    .item_i        (in_data_i),
    .max_payload_i (max_payload_q),
    .nxt_o         (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Parser state: advance only on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PH_SYNC1;
      state_q.sync_good  <= 1'b1;
      state_q.frame_len  <= '0;
      state_q.byte_count <= '0;
      state_q.sum_acc    <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid_i) begin
      max_payload_q <= cfg_data_i;
    end
  end

  // Result register: load on a transfer that yields a result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      out_data_q <= res;
    end
  end

  // Assertions
  a_phase_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q.phase))
    else $error("frame phase lost its one-hot code");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while a result is stalled");

  a_last_on_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.kind != KIND_DATA)))
    else $error("last flag does not match result kind");

  a_abort_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.abort |=> state_q.phase == PH_SYNC1)
    else $error("abort did not return the parser to sync hunting");

endmodule

`default_nettype wire

// File: design/bfr_step.sv
// ----------------------------------------------------------------------------
// bfr_step: per-byte frame parser update
// Combinational next state and optional result for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_step (
  input  bfr_pkg::state_t cur_i,
  input  bfr_pkg::in_t    item_i,
  input  logic [7:0]      max_payload_i,
  output bfr_pkg::state_t nxt_o,
  output logic            res_valid_o,
  output bfr_pkg::out_t   res_o
);
  import bfr_pkg::*;

  logic [7:0] b;
  logic [7:0] len_m1;
  logic [7:0] plen;
  logic [7:0] data;
  logic [7:0] cnt_inc;

  assign b       = item_i.rx_byte;
  assign len_m1  = b - 8'd1;
  assign plen    = cur_i.frame_len - 8'd1;
  assign data    = b - cur_i.byte_count;
  assign cnt_inc = cur_i.byte_count + 8'd1;

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_DATA;

    if (item_i.abort) begin
      // Drop the frame; idle hunting has nothing to drop
      res_valid_o = (cur_i.phase != PH_SYNC1) && (cur_i.phase inside
                    {PH_SYNC2, PH_LEN, PH_PAYLOAD, PH_CHECK, PH_SKIP});
      res_o.kind  = KIND_TIMEOUT;
      res_o.last  = 1'b1;
      nxt_o.phase = PH_SYNC1;
    end else begin
      case (cur_i.phase)
        PH_SYNC2: begin
          nxt_o.sync_good = cur_i.sync_good & (b == SYNC_BYTE);
          nxt_o.phase     = PH_LEN;
        end
        PH_LEN: begin
          if (!cur_i.sync_good) begin
            nxt_o.phase = PH_SYNC1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_SYNC;
            res_o.last  = 1'b1;
          end else begin
            nxt_o.frame_len  = b;
            nxt_o.byte_count = '0;
            if (b == 8'd0) begin
              nxt_o.phase = PH_SYNC1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_LEN;
              res_o.last  = 1'b1;
            end else if (len_m1 > max_payload_i) begin
              nxt_o.phase = PH_SKIP;
            end else begin
              nxt_o.sum_acc = b;
              nxt_o.phase   = (b == 8'd1) ? PH_CHECK : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          nxt_o.sum_acc    = cur_i.sum_acc + data;
          nxt_o.byte_count = cnt_inc;
          if (cnt_inc >= plen) begin
            nxt_o.phase = PH_CHECK;
          end
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_DATA;
          res_o.data_byte  = data;
          res_o.byte_index = cur_i.byte_count;
        end
        PH_CHECK: begin
          nxt_o.phase = PH_SYNC1;
          res_valid_o = 1'b1;
          res_o.last  = 1'b1;
          if ((b - plen) == (cur_i.sum_acc ^ CHK_XOR)) begin
            res_o.kind         = KIND_OK;
            res_o.frame_length = plen;
          end else begin
            res_o.kind = KIND_CHK;
          end
        end
        PH_SKIP: begin
          nxt_o.byte_count = cnt_inc;
          if (cnt_inc >= cur_i.frame_len) begin
            nxt_o.phase = PH_SYNC1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_LEN;
            res_o.last  = 1'b1;
          end
        end
        default: begin
          // First sync byte; unknown codes fall back here
          nxt_o.sync_good = (b == SYNC_BYTE);
          nxt_o.phase     = PH_SYNC2;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
